// ===== sv/itoa_pkg.sv =====
`default_nettype none

package itoa_pkg;

   // operand and digit sizes
   localparam int DATA_W   = 32;
   localparam int DIGIT_W  = 4;
   localparam int RADIX_W  = 5;
   localparam int CHAR_W   = 7;
   localparam int CMD_W    = 2;
   localparam int MAX_DIGITS = 32;
   localparam int STACK_W  = MAX_DIGITS * DIGIT_W;
   localparam int DCNT_W   = $clog2(MAX_DIGITS + 1);

   // conversion selector codes
   localparam logic [CMD_W-1:0] CMD_UNSIGNED = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SIGNED   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_HEX      = 2'd2;
   localparam logic [CMD_W-1:0] CMD_OCTAL    = 2'd3;

   // radix limits
   localparam logic [RADIX_W-1:0] RADIX_MIN     = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX     = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_HEX     = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_OCTAL   = 5'd8;
   localparam logic [RADIX_W-1:0] DEFAULT_RADIX = 5'd10;

   // ascii characters
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
   localparam logic [CHAR_W-1:0] CHAR_ALPHA_BASE = 7'h37;  // 'A' - 10

   // register map
   localparam logic REG_DECIMAL_BASE = 1'b0;

   // divider request and status
   typedef struct packed {
      logic               start;
      logic [DATA_W-1:0]  dividend;
      logic [RADIX_W-1:0] radix;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DATA_W-1:0]  quotient;
      logic [DIGIT_W-1:0] remainder;
   } div_rsp_type;

   // digit value to uppercase ascii
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] ext;
      ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      if (d < 4'd10) begin
         return CHAR_ZERO + ext;
      end
      return CHAR_ALPHA_BASE + ext;
   endfunction

endpackage

`default_nettype wire

// ===== sv/integer_to_ascii_formatter.sv =====
// Integer to ASCII formatter.
// The req channel takes one transaction per number: req_cmd selects unsigned
// or signed conversion in the programmable radix, hexadecimal with a "0x"
// prefix, or octal with a "0" prefix, and req_value is the 32-bit operand.
// The rsp channel returns the text one character per transaction, most
// significant digit first, with a leading '-' for signed negatives and a
// trailing space that carries rsp_last.
// The csr port holds decimal_base at address 0 (values below 2 act as 2,
// above 16 as 16); write it only while the block is idle.
// One shared restoring divider produces each digit, one quotient bit per
// cycle: each digit takes a start, 32 steps and a result handoff, and
// req_stall stays high until the trailing space has been loaded into the
// output register.
// A stalled rsp transaction holds in the output register and the
// sequencer waits on it. Reset empties the output register, returns the
// sequencer to idle and sets decimal_base to 10.
`default_nettype none

module integer_to_ascii_formatter (
   input  wire                            clock,
   input  wire                            reset,
   // request channel
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire  [itoa_pkg::CMD_W-1:0]     req_cmd,
   input  wire  [itoa_pkg::DATA_W-1:0]    req_value,
   // response channel
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [itoa_pkg::CHAR_W-1:0]    rsp_text_char,
   output logic                           rsp_last,
   // register port
   input  wire                            csr_psel,
   input  wire                            csr_penable,
   input  wire                            csr_pwrite,
   input  wire  [2:0]                     csr_paddr,
   input  wire  [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   // sequencer states
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_MINUS     = 3'd1;
   localparam logic [2:0] ST_ZERO      = 3'd2;
   localparam logic [2:0] ST_X         = 3'd3;
   localparam logic [2:0] ST_DIV_START = 3'd4;
   localparam logic [2:0] ST_DIV_WAIT  = 3'd5;
   localparam logic [2:0] ST_EMIT      = 3'd6;
   localparam logic [2:0] ST_SPACE     = 3'd7;

   logic [2:0]                       state_ff, state_in;
   logic [itoa_pkg::RADIX_W-1:0]     base_ff, base_in;
   logic [itoa_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic [itoa_pkg::DATA_W-1:0]      mag_ff, mag_in;
   logic [itoa_pkg::RADIX_W-1:0]     radix_ff, radix_in;
   logic [itoa_pkg::STACK_W-1:0]     stack_ff, stack_in;
   logic [itoa_pkg::DCNT_W-1:0]      dcnt_ff, dcnt_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [itoa_pkg::CHAR_W-1:0]      text_ff, text_in;
   logic                             last_ff, last_in;

   logic                             req_fire;
   logic                             out_free;
   logic                             emit;
   logic [itoa_pkg::CHAR_W-1:0]      emit_char;
   logic                             emit_last;
   logic                             csr_write;
   logic [itoa_pkg::RADIX_W-1:0]     base_eff;

   itoa_pkg::div_req_type            div_req;
   itoa_pkg::div_rsp_type            div_rsp;

   // register port
   always_comb begin
      csr_pready = 1'b1;
      csr_write  = csr_psel && csr_penable && csr_pwrite;
      base_in    = base_ff;
      if (csr_write && (csr_paddr[2] == itoa_pkg::REG_DECIMAL_BASE)) begin
         base_in = csr_pwdata[itoa_pkg::RADIX_W-1:0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == itoa_pkg::REG_DECIMAL_BASE) begin
         csr_prdata = {{(32-itoa_pkg::RADIX_W){1'b0}}, base_ff};
      end
   end

   // clamp the programmed radix to the supported range
   always_comb begin
      base_eff = base_ff;
      if (base_ff < itoa_pkg::RADIX_MIN) begin
         base_eff = itoa_pkg::RADIX_MIN;
      end else if (base_ff > itoa_pkg::RADIX_MAX) begin
         base_eff = itoa_pkg::RADIX_MAX;
      end
   end

   // handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      mag_in    = mag_ff;
      radix_in  = radix_ff;
      stack_in  = stack_ff;
      dcnt_in   = dcnt_ff;
      emit      = 1'b0;
      emit_char = itoa_pkg::CHAR_SPACE;
      emit_last = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = mag_ff;
      div_req.radix    = radix_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in  = req_cmd;
               dcnt_in = '0;
               mag_in  = req_value;
               unique case (req_cmd)
                  itoa_pkg::CMD_UNSIGNED: begin
                     radix_in = base_eff;
                     state_in = ST_DIV_START;
                  end
                  itoa_pkg::CMD_SIGNED: begin
                     radix_in = base_eff;
                     if (req_value[itoa_pkg::DATA_W-1]) begin
                        mag_in   = (~req_value) + 1'b1;
                        state_in = ST_MINUS;
                     end else begin
                        state_in = ST_DIV_START;
                     end
                  end
                  itoa_pkg::CMD_HEX: begin
                     radix_in = itoa_pkg::RADIX_HEX;
                     state_in = ST_ZERO;
                  end
                  default: begin
                     radix_in = itoa_pkg::RADIX_OCTAL;
                     state_in = ST_ZERO;
                  end
               endcase
            end
         end
         ST_MINUS: begin
            emit      = out_free;
            emit_char = itoa_pkg::CHAR_MINUS;
            if (out_free) begin
               state_in = ST_DIV_START;
            end
         end
         ST_ZERO: begin
            emit      = out_free;
            emit_char = itoa_pkg::CHAR_ZERO;
            if (out_free) begin
               state_in = (cmd_ff == itoa_pkg::CMD_HEX) ? ST_X : ST_DIV_START;
            end
         end
         ST_X: begin
            emit      = out_free;
            emit_char = itoa_pkg::CHAR_X;
            if (out_free) begin
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            // push the new low digit, keep dividing until the quotient is zero
            if (div_rsp.done) begin
               stack_in = {stack_ff[itoa_pkg::STACK_W-itoa_pkg::DIGIT_W-1:0],
                           div_rsp.remainder};
               dcnt_in  = dcnt_ff + 1'b1;
               mag_in   = div_rsp.quotient;
               state_in = (div_rsp.quotient == '0) ? ST_EMIT : ST_DIV_START;
            end
         end
         ST_EMIT: begin
            // pop digits, most significant first
            emit      = out_free;
            emit_char = itoa_pkg::digit_char(stack_ff[itoa_pkg::DIGIT_W-1:0]);
            if (out_free) begin
               stack_in = {{itoa_pkg::DIGIT_W{1'b0}},
                           stack_ff[itoa_pkg::STACK_W-1:itoa_pkg::DIGIT_W]};
               dcnt_in  = dcnt_ff - 1'b1;
               if (dcnt_ff == itoa_pkg::DCNT_W'(1)) begin
                  state_in = ST_SPACE;
               end
            end
         end
         ST_SPACE: begin
            emit      = out_free;
            emit_char = itoa_pkg::CHAR_SPACE;
            emit_last = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      text_in      = text_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         text_in      = emit_char;
         last_in      = emit_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = text_ff;
   assign rsp_last      = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= itoa_pkg::DEFAULT_RADIX;
         rsp_valid_ff <= 1'b0;
         dcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
         dcnt_ff      <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      mag_ff   <= mag_in;
      radix_ff <= radix_in;
      stack_ff <= stack_in;
      text_ff  <= text_in;
      last_ff  <= last_in;
   end

   // shared digit divider
   itoa_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // the final character is always the trailing space
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_text_char == itoa_pkg::CHAR_SPACE))
      else $error("last flag on a character other than space");

   // the digit stack never overflows and is never popped empty
   assert property (@(posedge clock) disable iff (reset)
      (dcnt_ff <= itoa_pkg::DCNT_W'(itoa_pkg::MAX_DIGITS)) &&
      ((state_ff != ST_EMIT) || (dcnt_ff != '0)))
      else $error("digit stack count out of range");

   // a divide is only started on an idle divider
   assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   // an accepted request leaves idle at once
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("request accepted without leaving idle");

endmodule

`default_nettype wire

// ===== sv/itoa_divider.sv =====
`default_nettype none

module itoa_divider (
   input  wire                        clock,
   input  wire                        reset,
   input  wire itoa_pkg::div_req_type div_req,
   output itoa_pkg::div_rsp_type      div_rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [$clog2(itoa_pkg::DATA_W)-1:0] cnt_ff, cnt_in;
   logic [itoa_pkg::DATA_W-1:0]         quo_ff, quo_in;
   logic [itoa_pkg::DIGIT_W-1:0]        rem_ff, rem_in;
   logic [itoa_pkg::RADIX_W-1:0]        radix_ff, radix_in;

   logic [itoa_pkg::RADIX_W-1:0] trial;
   logic                         ge;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, quo_ff[itoa_pkg::DATA_W-1]};
      ge    = (trial >= radix_ff);
   end

   // step control
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      if (div_req.start && !busy_ff) begin
         busy_in  = 1'b1;
         cnt_in   = '1;
         quo_in   = div_req.dividend;
         rem_in   = '0;
         radix_in = div_req.radix;
      end else if (busy_ff) begin
         quo_in = {quo_ff[itoa_pkg::DATA_W-2:0], ge};
         rem_in = ge ? itoa_pkg::DIGIT_W'(trial - radix_ff)
                     : trial[itoa_pkg::DIGIT_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
   end

   always_comb begin
      div_rsp.busy      = busy_ff;
      div_rsp.done      = done_ff;
      div_rsp.quotient  = quo_ff;
      div_rsp.remainder = rem_ff;
   end

   // a step result below the radix means the remainder always fits one digit
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> (rem_ff < radix_ff))
      else $error("divider remainder not below radix");

   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while busy");

   assert property (@(posedge clock) disable iff (reset)
      (div_req.start && !busy_ff) |=> busy_ff && !done_ff)
      else $error("divider did not start");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HOLD_CYCLES    = 600;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned END_PAUSE      = 60;
   localparam int unsigned PHASE_ITEMS    = 26;
   localparam logic [2:0]  ADDR_DECIMAL_BASE = {itoa_pkg::REG_DECIMAL_BASE, 2'b00};

   typedef struct {
      logic [itoa_pkg::CMD_W-1:0]  cmd;
      logic [itoa_pkg::DATA_W-1:0] value;
   } number_type;

   typedef struct {
      logic [itoa_pkg::CHAR_W-1:0] text_char;
      logic                        last;
   } text_char_type;

   // dut signals, all inputs start at known values
   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_stall;
   logic [itoa_pkg::CMD_W-1:0]    req_cmd     = itoa_pkg::CMD_UNSIGNED;
   logic [itoa_pkg::DATA_W-1:0]   req_value   = '0;
   logic                          rsp_valid;
   logic                          rsp_stall   = 1'b0;
   logic [itoa_pkg::CHAR_W-1:0]   rsp_text_char;
   logic                          rsp_last;
   logic                          csr_psel    = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite  = 1'b0;
   logic [2:0]                    csr_paddr   = '0;
   logic [31:0]                   csr_pwdata  = '0;
   logic [31:0]                   csr_prdata;
   logic                          csr_pready;

   // numbers waiting to be sent and characters waiting to arrive
   number_type                    pending_numbers[$];
   text_char_type                 expected_chars[$];
   logic [itoa_pkg::RADIX_W-1:0]  base_shadow = itoa_pkg::DEFAULT_RADIX;

   int unsigned         fail_count    = 0;
   int unsigned         numbers_sent  = 0;
   int unsigned         chars_checked = 0;
   int unsigned         radix_writes  = 0;
   int unsigned         idle_cycles   = 0;

   bit                  send_quiet = 1'b0;
   bit                  recv_quiet = 1'b0;
   bit                  hold_arm   = 1'b0;

   bit                  drv_offer;
   number_type          drv_next;
   int unsigned         send_gap  = 0;
   bit                  mon_stall;
   int unsigned         recv_gap  = 0;
   int unsigned         hold_left = 0;

   integer_to_ascii_formatter dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_text_char (rsp_text_char),
      .rsp_last      (rsp_last),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // idle span per transaction, with runs of back-to-back traffic
   function automatic int unsigned idle_span(input bit quiet);
      if (quiet || $urandom_range(0, 2) == 0) begin
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   function automatic void push_char(input logic [itoa_pkg::CHAR_W-1:0] ch,
                                     input logic last);
      text_char_type entry;
      entry.text_char = ch;
      entry.last      = last;
      expected_chars.push_back(entry);
   endfunction

   // digits of mag in the given radix, most significant first
   function automatic void push_digits(input logic [itoa_pkg::DATA_W-1:0] mag,
                                       input logic [itoa_pkg::RADIX_W-1:0] radix);
      logic [itoa_pkg::CHAR_W-1:0] rev[$];
      logic [itoa_pkg::DATA_W-1:0] rest;
      logic [3:0]                  d;
      rest = mag;
      if (rest == '0) begin
         push_char(itoa_pkg::CHAR_ZERO, 1'b0);
         return;
      end
      while (rest != '0) begin
         d = 4'(rest % itoa_pkg::DATA_W'(radix));
         if (d < 4'd10) begin
            rev.push_front(7'h30 + itoa_pkg::CHAR_W'(d));
         end else begin
            rev.push_front(7'h41 + itoa_pkg::CHAR_W'(d) - 7'd10);
         end
         rest = rest / itoa_pkg::DATA_W'(radix);
      end
      foreach (rev[i]) begin
         push_char(rev[i], 1'b0);
      end
   endfunction

   // expected text of one number under the current radix setting
   function automatic void format_number(input logic [itoa_pkg::CMD_W-1:0] cmd,
                                         input logic [itoa_pkg::DATA_W-1:0] value);
      logic [itoa_pkg::RADIX_W-1:0] radix;
      radix = base_shadow;
      if (radix < itoa_pkg::RADIX_MIN) begin
         radix = itoa_pkg::RADIX_MIN;
      end else if (radix > itoa_pkg::RADIX_MAX) begin
         radix = itoa_pkg::RADIX_MAX;
      end
      case (cmd)
         itoa_pkg::CMD_UNSIGNED: begin
            push_digits(value, radix);
         end
         itoa_pkg::CMD_SIGNED: begin
            if (value[itoa_pkg::DATA_W-1]) begin
               push_char(itoa_pkg::CHAR_MINUS, 1'b0);
               push_digits((~value) + 32'd1, radix);
            end else begin
               push_digits(value, radix);
            end
         end
         itoa_pkg::CMD_HEX: begin
            push_char(itoa_pkg::CHAR_ZERO, 1'b0);
            push_char(itoa_pkg::CHAR_X, 1'b0);
            push_digits(value, itoa_pkg::RADIX_HEX);
         end
         default: begin
            push_char(itoa_pkg::CHAR_ZERO, 1'b0);
            push_digits(value, itoa_pkg::RADIX_OCTAL);
         end
      endcase
      push_char(itoa_pkg::CHAR_SPACE, 1'b1);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_cmd   <= itoa_pkg::CMD_UNSIGNED;
         req_value <= '0;
         send_gap  = 0;
      end else begin
         drv_offer = req_valid;
         if (req_valid && !req_stall) begin
            format_number(req_cmd, req_value);
            numbers_sent++;
            drv_offer = 1'b0;
            send_gap  = idle_span(send_quiet);
         end
         if (!drv_offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_numbers.size() != 0) begin
               drv_next = pending_numbers.pop_front();
               req_cmd   <= drv_next.cmd;
               req_value <= drv_next.value;
               drv_offer = 1'b1;
            end
         end
         req_valid <= drv_offer;
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap  = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected character, expected none got %h last %b",
                        $time, rsp_text_char, rsp_last);
               fail_count++;
            end else begin
               if (rsp_text_char !== expected_chars[0].text_char) begin
                  $display("%0t: text_char mismatch, expected %h got %h",
                           $time, expected_chars[0].text_char, rsp_text_char);
                  fail_count++;
               end
               if (rsp_last !== expected_chars[0].last) begin
                  $display("%0t: last mismatch, expected %b got %b",
                           $time, expected_chars[0].last, rsp_last);
                  fail_count++;
               end
               void'(expected_chars.pop_front());
            end
            recv_gap = idle_span(recv_quiet);
         end
         // long hold-off so the block backs up into the request side
         if (hold_arm && rsp_valid) begin
            hold_left = HOLD_CYCLES;
            hold_arm  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            mon_stall = 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            mon_stall = 1'b1;
         end else begin
            mon_stall = 1'b0;
         end
         rsp_stall <= mon_stall;
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   task automatic queue_number(input logic [itoa_pkg::CMD_W-1:0] cmd,
                               input logic [itoa_pkg::DATA_W-1:0] value);
      number_type item;
      item.cmd   = cmd;
      item.value = value;
      pending_numbers.push_back(item);
   endtask

   // also waits on a number just popped but not yet visible on req_valid
   task automatic wait_drained();
      while (pending_numbers.size() != 0 || req_valid || drv_offer ||
             expected_chars.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // apb write of decimal_base, then read it back
   task automatic set_radix(input logic [itoa_pkg::RADIX_W-1:0] setting);
      logic [31:0] wdata;
      wdata = $urandom;
      wdata[itoa_pkg::RADIX_W-1:0] = setting;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_DECIMAL_BASE;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      base_shadow = setting;
      radix_writes++;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[itoa_pkg::RADIX_W-1:0] !== base_shadow) begin
         $display("%0t: decimal_base readback mismatch, expected %0d got %0d",
                  $time, base_shadow, csr_prdata[itoa_pkg::RADIX_W-1:0]);
         fail_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [itoa_pkg::DATA_W-1:0] random_value();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 3))
               0:       return 32'h0000_0000;
               1:       return 32'hFFFF_FFFF;
               2:       return 32'h8000_0000;
               default: return 32'h7FFF_FFFF;
            endcase
         end
         1:       return itoa_pkg::DATA_W'($urandom_range(0, 300));
         2:       return $urandom >> $urandom_range(0, 31);
         3:       return $urandom | 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // stimulus
   initial begin
      logic [itoa_pkg::RADIX_W-1:0] phase_bases[8];
      logic [itoa_pkg::CMD_W-1:0]   cmd;
      phase_bases = '{5'd10, 5'd2, 5'd16, 5'd7, 5'd3, 5'd0, 5'd31, 5'd13};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      base_shadow = itoa_pkg::DEFAULT_RADIX;

      // extremes in the default radix, all conversions
      send_quiet = 1'b1;
      recv_quiet = 1'b1;
      queue_number(itoa_pkg::CMD_UNSIGNED, 32'h0000_0000);
      queue_number(itoa_pkg::CMD_UNSIGNED, 32'hFFFF_FFFF);
      queue_number(itoa_pkg::CMD_UNSIGNED, 32'h0000_0001);
      queue_number(itoa_pkg::CMD_SIGNED,   32'h0000_0000);
      queue_number(itoa_pkg::CMD_SIGNED,   32'h7FFF_FFFF);
      queue_number(itoa_pkg::CMD_SIGNED,   32'h8000_0000);
      queue_number(itoa_pkg::CMD_SIGNED,   32'hFFFF_FFFF);
      queue_number(itoa_pkg::CMD_SIGNED,   32'hFFFF_CFC7);
      queue_number(itoa_pkg::CMD_HEX,      32'h0000_0000);
      queue_number(itoa_pkg::CMD_HEX,      32'hFFFF_FFFF);
      queue_number(itoa_pkg::CMD_HEX,      32'h0123_ABCD);
      queue_number(itoa_pkg::CMD_OCTAL,    32'h0000_0000);
      queue_number(itoa_pkg::CMD_OCTAL,    32'hFFFF_FFFF);
      queue_number(itoa_pkg::CMD_OCTAL,    32'h0000_0008);
      queue_number(itoa_pkg::CMD_UNSIGNED, 32'h0000_0009);
      wait_drained();

      // binary: the longest text is the most negative signed value
      set_radix(5'd2);
      queue_number(itoa_pkg::CMD_SIGNED,   32'h8000_0000);
      queue_number(itoa_pkg::CMD_UNSIGNED, 32'hFFFF_FFFF);
      queue_number(itoa_pkg::CMD_UNSIGNED, 32'h0000_0000);
      wait_drained();
      set_radix(5'd16);
      queue_number(itoa_pkg::CMD_UNSIGNED, 32'hFEDC_BA98);
      queue_number(itoa_pkg::CMD_SIGNED,   32'h8000_0001);
      wait_drained();

      // radix settings outside 2..16 clamp to the nearest limit
      set_radix(5'd0);
      queue_number(itoa_pkg::CMD_UNSIGNED, 32'h0000_0005);
      queue_number(itoa_pkg::CMD_SIGNED,   32'hFFFF_FFFF);
      wait_drained();
      set_radix(5'd1);
      queue_number(itoa_pkg::CMD_UNSIGNED, 32'h0000_00AA);
      wait_drained();
      set_radix(5'd17);
      queue_number(itoa_pkg::CMD_UNSIGNED, 32'h00AB_CDEF);
      wait_drained();
      set_radix(5'd31);
      queue_number(itoa_pkg::CMD_UNSIGNED, 32'h1234_5678);
      wait_drained();

      // random phases, one radix setting each
      foreach (phase_bases[p]) begin
         set_radix(phase_bases[p]);
         send_quiet = ($urandom_range(0, 3) == 0);
         recv_quiet = ($urandom_range(0, 3) == 0);
         if (p == 2) begin
            send_quiet = 1'b1;
            hold_arm   = 1'b1;
         end
         if (p == 4) begin
            send_quiet = 1'b1;
            recv_quiet = 1'b1;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            cmd = itoa_pkg::CMD_W'($urandom_range(0, 3));
            queue_number(cmd, random_value());
         end
         wait_drained();
      end

      repeat (END_PAUSE) @(posedge clock);
      if (expected_chars.size() != 0) begin
         $display("%0t: %0d characters never arrived", $time, expected_chars.size());
         fail_count++;
      end
      $display("covered %0d numbers in all four conversions over %0d radix writes,",
               numbers_sent, radix_writes);
      $display("%0d characters checked, with random stalls and one long hold-off",
               chars_checked);
      if (fail_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/itoa_pkg.sv
sv/itoa_divider.sv
sv/integer_to_ascii_formatter.sv
tb/tb_top.sv
